// File: rtl/sitda_pkg.sv
// Shared constants, types and helper functions for the integer-to-decimal-text block.
package sitda_pkg;

  // Width of the signed input value.
  localparam int ValueWidth = 32;

  // ASCII output codes, held to six bits.
  localparam int CharWidth = 6;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;
  localparam logic [CharWidth-1:0] CharZero  = 6'd48;

  // Decimal digits needed for any magnitude: floor(W * log10(2)) + 1.
  localparam int MaxDigits = ((ValueWidth * 1233) >> 12) + 1;
  localparam int DigIdxW   = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;

  // Binary-to-BCD conversion retires this many magnitude bits per cycle.
  localparam int StepBits = 4;
  localparam int Steps    = (ValueWidth + StepBits - 1) / StepBits;
  localparam int PadWidth = Steps * StepBits;
  localparam int StepCntW = (Steps > 1) ? $clog2(Steps) : 1;

  // Entries in the queue between the converter and the character emitter.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Packed BCD word, digit 0 is the least significant.
  typedef logic [MaxDigits-1:0][3:0] bcd_t;

  // One converted value waiting for the emitter.
  typedef struct packed {
    logic               negative;
    bcd_t               digits;
    logic [DigIdxW-1:0] msd;
  } entry_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    FeIdle,
    FeConv,
    FeHold
  } front_state_e;

  typedef enum logic [1:0] {
    BeIdle,
    BeSign,
    BeDigit
  } back_state_e;

  // One double-dabble step: correct every digit of five or more, then shift one bit in.
  function automatic bcd_t dd_shift(bcd_t bcd, logic bit_in);
    bcd_t adj;
    adj = bcd;
    for (int i = 0; i < MaxDigits; i++) begin
      if (adj[i] >= 4'd5) begin
        adj[i] = adj[i] + 4'd3;
      end
    end
    return bcd_t'({adj, bit_in});
  endfunction

  // Index of the most significant nonzero digit, zero for a zero word.
  function automatic logic [DigIdxW-1:0] msd_index(bcd_t b);
    logic [DigIdxW-1:0] idx;
    idx = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (b[i] != 4'd0) begin
        idx = DigIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, front converter, queue and emitter.
//
//   Channel   Ports                                  Transfer
//   input     start_i, busy_o, value_i               start_i high while busy_o is low
//   result    char_valid_o, character_o, last_o      every cycle char_valid_o is high
//
// The front end takes a value, converts its magnitude to BCD four bits per cycle and
// hands it to a two-entry queue, waiting while the queue is full; it takes no new value
// until the last one is handed over. The emitter sends one character per cycle, up to
// 11 per value, with no gap between values while the queue holds the next one. Reset
// clears all control state. The receiver cannot stall.
module signed_int_to_decimal_ascii (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  output logic                                     busy_o,
  input  logic signed [sitda_pkg::ValueWidth-1:0]  value_i,
  output logic                                     char_valid_o,
  output logic [sitda_pkg::CharWidth-1:0]          character_o,
  output logic                                     last_o
);

  logic                     push;
  logic                     pop;
  sitda_pkg::entry_t        push_data;
  sitda_pkg::entry_t        pop_data;
  sitda_pkg::queue_status_t q_status;

  sitda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .push_o      (push),
    .push_data_o (push_data),
    .q_status_i  (q_status)
  );

  sitda_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  sitda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_data_i   (pop_data),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .last_o       (last_o)
  );

endmodule

// File: rtl/sitda_front.sv
// Front end: takes a value, splits off the sign and converts the magnitude to BCD.
module sitda_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [sitda_pkg::ValueWidth-1:0] value_i,
  output logic                                 busy_o,
  output logic                                 push_o,
  output sitda_pkg::entry_t                    push_data_o,
  input  sitda_pkg::queue_status_t             q_status_i
);

  sitda_pkg::front_state_e             state_q, state_d;
  logic [sitda_pkg::StepCntW-1:0]      cnt_q, cnt_d;
  logic [sitda_pkg::PadWidth-1:0]      bin_q, bin_d;
  sitda_pkg::bcd_t                     bcd_q, bcd_d;
  logic                                neg_q, neg_d;
  logic [sitda_pkg::ValueWidth-1:0]    raw;
  logic [sitda_pkg::ValueWidth-1:0]    mag;
  logic                                accept;
  logic                                conv_done;
  sitda_pkg::bcd_t                     bcd_step;

  assign accept    = start_i && (state_q == sitda_pkg::FeIdle);
  assign conv_done = (cnt_q == sitda_pkg::StepCntW'(sitda_pkg::Steps - 1));

  // Two's complement magnitude; the most negative value wraps onto its unsigned form.
  assign raw = unsigned'(value_i);
  assign mag = raw[sitda_pkg::ValueWidth-1] ? (~raw + 1'b1) : raw;

  // Several double-dabble steps per cycle, most significant bits first.
  always_comb begin
    bcd_step = bcd_q;
    for (int j = 0; j < sitda_pkg::StepBits; j++) begin
      bcd_step = sitda_pkg::dd_shift(bcd_step, bin_q[sitda_pkg::PadWidth-1-j]);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sitda_pkg::FeIdle: begin
        if (start_i) begin
          state_d = sitda_pkg::FeConv;
        end
      end
      sitda_pkg::FeConv: begin
        if (conv_done) begin
          state_d = sitda_pkg::FeHold;
        end
      end
      sitda_pkg::FeHold: begin
        if (!q_status_i.full) begin
          state_d = sitda_pkg::FeIdle;
        end
      end
      default: state_d = sitda_pkg::FeIdle;
    endcase
  end

  // Datapath updates and handshake outputs.
  always_comb begin
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    busy_o = 1'b1;
    push_o = 1'b0;
    unique case (state_q)
      sitda_pkg::FeIdle: begin
        busy_o = 1'b0;
        if (accept) begin
          neg_d = raw[sitda_pkg::ValueWidth-1];
          bin_d = sitda_pkg::PadWidth'(mag);
          bcd_d = '0;
          cnt_d = '0;
        end
      end
      sitda_pkg::FeConv: begin
        bcd_d = bcd_step;
        bin_d = bin_q << sitda_pkg::StepBits;
        cnt_d = cnt_q + 1'b1;
      end
      sitda_pkg::FeHold: begin
        push_o = !q_status_i.full;
      end
      default: busy_o = 1'b1;
    endcase
  end

  assign push_data_o.negative = neg_q;
  assign push_data_o.digits   = bcd_q;
  assign push_data_o.msd      = sitda_pkg::msd_index(bcd_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::FeIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Conversion registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule

// File: rtl/sitda_fifo.sv
// Short queue of converted values between the front end and the emitter.
module sitda_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  sitda_pkg::entry_t        push_data_i,
  input  logic                     pop_i,
  output sitda_pkg::entry_t        pop_data_o,
  output sitda_pkg::queue_status_t status_o
);

  sitda_pkg::entry_t              mem_q [sitda_pkg::QueueDepth];
  logic [sitda_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [sitda_pkg::QPtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [sitda_pkg::QCntW-1:0]    count_q, count_d;

  assign status_o.full  = (count_q == sitda_pkg::QCntW'(sitda_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer and fill-count updates; pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == sitda_pkg::QPtrW'(sitda_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == sitda_pkg::QPtrW'(sitda_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/sitda_back.sv
// Back end: emits the sign and the digits of one queued value, one character per cycle.
module sitda_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sitda_pkg::entry_t                  pop_data_i,
  input  sitda_pkg::queue_status_t           q_status_i,
  output logic                               pop_o,
  output logic                               char_valid_o,
  output logic [sitda_pkg::CharWidth-1:0]    character_o,
  output logic                               last_o
);

  sitda_pkg::back_state_e          state_q, state_d;
  sitda_pkg::bcd_t                 digits_q, digits_d;
  logic [sitda_pkg::DigIdxW-1:0]   pos_q, pos_d;
  logic                            final_char;
  logic                            load;

  assign final_char = (state_q == sitda_pkg::BeDigit) && (pos_q == '0);
  assign load       = ((state_q == sitda_pkg::BeIdle) || final_char) && !q_status_i.empty;
  assign pop_o      = load;

  // Next state: a new value starts right after the last character of the previous one if the queue is not empty.
  always_comb begin
    state_d  = state_q;
    digits_d = digits_q;
    pos_d    = pos_q;
    if (load) begin
      state_d  = pop_data_i.negative ? sitda_pkg::BeSign : sitda_pkg::BeDigit;
      digits_d = pop_data_i.digits;
      pos_d    = pop_data_i.msd;
    end else begin
      unique case (state_q)
        sitda_pkg::BeIdle:  state_d = sitda_pkg::BeIdle;
        sitda_pkg::BeSign:  state_d = sitda_pkg::BeDigit;
        sitda_pkg::BeDigit: begin
          if (pos_q == '0) begin
            state_d = sitda_pkg::BeIdle;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
        default: state_d = sitda_pkg::BeIdle;
      endcase
    end
  end

  // Character outputs.
  always_comb begin
    char_valid_o = 1'b0;
    character_o  = sitda_pkg::CharZero;
    last_o       = 1'b0;
    unique case (state_q)
      sitda_pkg::BeIdle: begin
        char_valid_o = 1'b0;
      end
      sitda_pkg::BeSign: begin
        char_valid_o = 1'b1;
        character_o  = sitda_pkg::CharMinus;
      end
      sitda_pkg::BeDigit: begin
        char_valid_o = 1'b1;
        character_o  = sitda_pkg::CharZero + sitda_pkg::CharWidth'(digits_q[pos_q]);
        last_o       = final_char;
      end
      default: char_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::BeIdle;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
  end

endmodule

// File: tb/sv/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII text block.
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW           = sitda_pkg::ValueWidth;
  localparam int DecimalBase  = 10;
  localparam int DigitSlots   = 20;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 30;

  // One character of rendered text as the block should emit it.
  typedef struct packed {
    logic [sitda_pkg::CharWidth-1:0] character;
    logic                            last;
  } text_char_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start_i;
  logic                            busy_o;
  logic signed [VW-1:0]            value_i;
  logic                            char_valid_o;
  logic [sitda_pkg::CharWidth-1:0] character_o;
  logic                            last_o;

  text_char_t pending_text[$];
  int         error_count;
  int         stall_cycles;

  signed_int_to_decimal_ascii u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_i      (value_i),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Render one value as decimal text and queue its characters.
  function automatic void render_decimal(logic [VW-1:0] raw);
    logic          negative;
    logic [VW-1:0] magnitude;
    int            digit_buf[DigitSlots];
    int            ndigits;
    text_char_t    ch;
    negative  = raw[VW-1];
    magnitude = negative ? (~raw + 1'b1) : raw;
    ndigits   = 0;
    do begin
      digit_buf[ndigits] = int'(magnitude % DecimalBase);
      ndigits++;
      magnitude = magnitude / DecimalBase;
    end while (magnitude != 0 && ndigits < DigitSlots);
    if (negative) begin
      ch.character = sitda_pkg::CharMinus;
      ch.last      = 1'b0;
      pending_text.push_back(ch);
    end
    for (int k = ndigits - 1; k >= 0; k--) begin
      ch.character = sitda_pkg::CharZero + sitda_pkg::CharWidth'(digit_buf[k]);
      ch.last      = (k == 0);
      pending_text.push_back(ch);
    end
  endfunction

  // Pick a value: either raw random bits or a random magnitude of a chosen digit count.
  function automatic logic [VW-1:0] random_value();
    int unsigned ndigits;
    longint      lo;
    longint      hi;
    longint      cap;
    longint      magnitude;
    logic        negative;
    if ($urandom_range(3) == 0) begin
      return VW'($urandom);
    end
    negative = 1'($urandom_range(1));
    ndigits  = $urandom_range(10, 1);
    lo = 1;
    for (int i = 1; i < ndigits; i++) begin
      lo = lo * DecimalBase;
    end
    hi  = (ndigits == 1) ? 9 : lo * DecimalBase - 1;
    lo  = (ndigits == 1) ? 0 : lo;
    cap = negative ? (longint'(1) << (VW - 1)) : (longint'(1) << (VW - 1)) - 1;
    if (hi > cap) begin
      hi = cap;
    end
    magnitude = lo + longint'($urandom) % (hi - lo + 1);
    return negative ? VW'(-magnitude) : VW'(magnitude);
  endfunction

  // Present one value, after a random gap, and hold it until the block takes it.
  task automatic send_value(input logic [VW-1:0] v, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      value_i <= VW'($urandom);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    render_decimal(v);
  endtask

  // Extremes, digit-count boundaries and the most negative value.
  task automatic test_directed_values();
    logic [VW-1:0] corner[$];
    corner = '{VW'(0), VW'(1), VW'(-1), VW'(9), VW'(-9), VW'(10), VW'(-10),
               VW'(99), VW'(100), VW'(-100), VW'(123456789), VW'(999999999),
               VW'(1000000000), VW'(-1000000000), VW'(-999999999),
               VW'(2147483647), VW'(-2147483647), {1'b1, {(VW-1){1'b0}}},
               {(VW/2){2'b01}}, {(VW/2){2'b10}}, VW'(1000000001)};
    foreach (corner[i]) begin
      send_value(corner[i], (i % 3 == 0) ? 24 : 0);
    end
  endtask

  // Random values with the given sender idle rate.
  task automatic test_random_values(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      send_value(random_value(), idle_pct);
    end
  endtask

  // Compare each character transfer with the oldest expected one; watch for a stall.
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && char_valid_o) begin
      if (pending_text.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char=%0d last=%0b",
                 $time, character_o, last_o);
        error_count++;
      end else begin
        want = pending_text.pop_front();
        if (character_o !== want.character || last_o !== want.last) begin
          $display("%0t: mismatch: expected char=%0d last=%0b, actual char=%0d last=%0b",
                   $time, want.character, want.last, character_o, last_o);
          error_count++;
        end
      end
    end
    if (!rst_ni || char_valid_o || (start_i && !busy_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Reset, run every test in turn, drain and report.
  initial begin
    error_count  = 0;
    stall_cycles = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    value_i      = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_random_values(70, 24);
    test_random_values(70, 59);
    test_random_values(60, 0);
    start_i <= 1'b0;
    while (pending_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
